// File: rtl/core/pfe_pkg.sv
// shared types, constants and helper functions of the playfair digraph encryptor
package pfe_pkg;

	localparam int SQ_SIDE  = 5;
	localparam int SQ_CELLS = 25;
	localparam int LETTERS  = 26;
	localparam int LTR_W    = 5;
	localparam int CELL_W   = 5;
	localparam int RC_W     = 3;

	localparam logic [LTR_W-1:0] IDX_I       = 5'd8;
	localparam logic [LTR_W-1:0] IDX_J       = 5'd9;
	localparam logic [LTR_W-1:0] IDX_X       = 5'd23;
	localparam logic [LTR_W-1:0] LAST_LETTER = 5'd25;

	localparam logic [7:0] ASCII_A_UP = 8'h41;
	localparam logic [7:0] ASCII_Z_UP = 8'h5A;
	localparam logic [7:0] ASCII_A_LO = 8'h61;
	localparam logic [7:0] ASCII_Z_LO = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [1:0] {
		CMD_KEY  = 2'd0,
		CMD_END  = 2'd1,
		CMD_MSG  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic             ok;
		logic [LTR_W-1:0] idx;
	} letter_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fill_step;
		logic rd_b;
		logic calc;
		logic rd_o2;
		logic cap2;
		logic emit_second;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_fill;
		logic start_pair;
		logic fill_done;
	} dp_sts_t;

	function automatic letter_t letter_of(input logic [7:0] code);
		letter_t    r;
		logic [7:0] c;
		c = code;
		if (c >= ASCII_A_LO && c <= ASCII_Z_LO) begin
			c = c - CASE_DIFF;
		end
		r.ok  = (c >= ASCII_A_UP) && (c <= ASCII_Z_UP);
		r.idx = LTR_W'(c - ASCII_A_UP);
		if (r.idx == IDX_J) begin
			r.idx = IDX_I;
		end
		return r;
	endfunction

	function automatic logic [RC_W-1:0] row_of(input logic [CELL_W-1:0] p);
		logic [RC_W-1:0] r;
		priority if (p >= CELL_W'(20)) r = 3'd4;
		else if (p >= CELL_W'(15)) r = 3'd3;
		else if (p >= CELL_W'(10)) r = 3'd2;
		else if (p >= CELL_W'(5)) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] cell_of(input logic [RC_W-1:0] r,
			input logic [RC_W-1:0] c);
		return {r, 2'b00} + CELL_W'(r) + CELL_W'(c);
	endfunction

	function automatic logic [RC_W-1:0] col_of(input logic [CELL_W-1:0] p);
		return RC_W'(p - cell_of(row_of(p), 3'd0));
	endfunction

	function automatic logic [RC_W-1:0] next_rc(input logic [RC_W-1:0] x);
		return (x == RC_W'(SQ_SIDE - 1)) ? 3'd0 : x + 3'd1;
	endfunction

endpackage

// File: rtl/core/pfe_ram.sv
// generic single-write, single-read ram with registered read data
module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/pfe_ctrl.sv
// controller state machine: accept, square fill walk, lookup sequence, result letters
module pfe_ctrl import pfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FILL  = 9'b000000010,
		ST_RDA   = 9'b000000100,
		ST_RDB   = 9'b000001000,
		ST_CALC  = 9'b000010000,
		ST_RD2   = 9'b000100000,
		ST_CAP2  = 9'b001000000,
		ST_EMIT1 = 9'b010000000,
		ST_EMIT2 = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign fire      = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT1) || (state_q == ST_EMIT2);

	assign cmd.accept      = fire;
	assign cmd.fill_step   = (state_q == ST_FILL);
	assign cmd.rd_b        = (state_q == ST_RDB);
	assign cmd.calc        = (state_q == ST_CALC);
	assign cmd.rd_o2       = (state_q == ST_RD2);
	assign cmd.cap2        = (state_q == ST_CAP2);
	assign cmd.emit_second = (state_q == ST_EMIT2);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire && sts.start_fill) begin
					state_d = ST_FILL;
				end else if (fire && sts.start_pair) begin
					state_d = ST_RDA;
				end
			end
			ST_FILL: begin
				if (sts.fill_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_CALC;
			ST_CALC: state_d = ST_RD2;
			ST_RD2:  state_d = ST_CAP2;
			ST_CAP2: state_d = ST_EMIT1;
			ST_EMIT1: begin
				if (out_ready) begin
					state_d = ST_EMIT2;
				end
			end
			ST_EMIT2: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/pfe_datapath.sv
// datapath: key square and letter position rams, pairing, digraph lookup
module pfe_datapath import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  in_cmd,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	output logic [6:0]  out_letter,
	output logic        out_end
);

	letter_t            ltr;
	cmd_t               kind;
	logic [LETTERS-1:0] used_q, used_d;
	logic [LTR_W-1:0]   fill_q, fill_d, fill_w;
	logic               key_ready_q, key_ready_d;
	logic               holding_q, holding_d;
	logic [LTR_W-1:0]   held_q, held_d;
	logic [LTR_W-1:0]   fill_ltr_q;
	logic               pl_en, pl_we;
	logic [LTR_W-1:0]   pl_v;
	logic               pair_go;
	logic [LTR_W-1:0]   pair_a, pair_b;
	logic               pair_end;
	logic [LTR_W-1:0]   a_q, b_q;
	logic               end_q;
	logic [CELL_W-1:0]  p1_q, o2_q, o1, o2;
	logic [LTR_W-1:0]   l1_q, l2_q;
	logic [CELL_W-1:0]  pos_rdata, pos_raddr, ks_raddr;
	logic [LTR_W-1:0]   ks_rdata;
	logic [RC_W-1:0]    r1, c1, r2, c2;

	assign ltr  = letter_of(in_char);
	assign kind = cmd_t'(in_cmd);

	always_comb begin
		used_d      = used_q;
		fill_d      = fill_q;
		key_ready_d = key_ready_q;
		holding_d   = holding_q;
		held_d      = held_q;
		pl_en       = 1'b0;
		pl_v        = ltr.idx;
		pair_go     = 1'b0;
		pair_a      = held_q;
		pair_b      = IDX_X;
		pair_end    = 1'b1;
		unique case (kind)
			CMD_KEY: begin
				if (key_ready_q) begin
					used_d      = '0;
					fill_d      = '0;
					key_ready_d = 1'b0;
					holding_d   = 1'b0;
					held_d      = '0;
				end
				pl_en = ltr.ok;
			end
			CMD_MSG: begin
				if (key_ready_q) begin
					if (!ltr.ok) begin
						if (in_last && holding_q) begin
							pair_go   = 1'b1;
							holding_d = 1'b0;
						end
					end else if (holding_q) begin
						pair_go   = 1'b1;
						pair_b    = ltr.idx;
						pair_end  = in_last;
						holding_d = 1'b0;
					end else if (in_last) begin
						pair_go = 1'b1;
						pair_a  = ltr.idx;
					end else begin
						held_d    = ltr.idx;
						holding_d = 1'b1;
					end
				end
			end
			CMD_END, CMD_NONE: ;
			default: ;
		endcase
		if (!cmd.accept) begin
			used_d      = used_q;
			fill_d      = fill_q;
			key_ready_d = key_ready_q;
			holding_d   = holding_q;
			held_d      = held_q;
			pl_en       = 1'b0;
		end
		if (cmd.fill_step) begin
			pl_en = (fill_ltr_q != IDX_J);
			pl_v  = fill_ltr_q;
			if (fill_ltr_q == LAST_LETTER) begin
				key_ready_d = 1'b1;
			end
		end
		fill_w = fill_d;
		pl_we  = pl_en && (fill_d < LTR_W'(SQ_CELLS)) && !used_d[pl_v];
		if (pl_we) begin
			used_d[pl_v] = 1'b1;
			fill_d       = fill_d + 5'd1;
		end
	end

	assign sts.start_fill = (kind == CMD_END) && !key_ready_q;
	assign sts.start_pair = pair_go;
	assign sts.fill_done  = (fill_ltr_q == LAST_LETTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fill_q      <= '0;
			key_ready_q <= 1'b0;
			holding_q   <= 1'b0;
			held_q      <= '0;
			fill_ltr_q  <= '0;
		end else begin
			used_q      <= used_d;
			fill_q      <= fill_d;
			key_ready_q <= key_ready_d;
			holding_q   <= holding_d;
			held_q      <= held_d;
			if (cmd.accept) begin
				fill_ltr_q <= '0;
			end else if (cmd.fill_step) begin
				fill_ltr_q <= fill_ltr_q + 5'd1;
			end
		end
	end

	// pair operands, lookup results
	always_ff @(posedge clk) begin
		if (cmd.accept && pair_go) begin
			a_q   <= pair_a;
			b_q   <= (pair_b == pair_a) ? IDX_X : pair_b;
			end_q <= pair_end;
		end
		if (cmd.rd_b) begin
			p1_q <= pos_rdata;
		end
		if (cmd.calc) begin
			o2_q <= o2;
		end
		if (cmd.rd_o2) begin
			l1_q <= ks_rdata;
		end
		if (cmd.cap2) begin
			l2_q <= ks_rdata;
		end
	end

	assign r1 = row_of(p1_q);
	assign c1 = col_of(p1_q);
	assign r2 = row_of(pos_rdata);
	assign c2 = col_of(pos_rdata);

	always_comb begin
		priority if (r1 == r2) begin
			o1 = cell_of(r1, next_rc(c1));
			o2 = cell_of(r2, next_rc(c2));
		end else if (c1 == c2) begin
			o1 = cell_of(next_rc(r1), c1);
			o2 = cell_of(next_rc(r2), c2);
		end else begin
			o1 = cell_of(r1, c2);
			o2 = cell_of(r2, c1);
		end
	end

	assign pos_raddr = cmd.rd_b ? b_q : a_q;
	assign ks_raddr  = cmd.rd_o2 ? o2_q : o1;

	pfe_ram #(
		.WIDTH (CELL_W),
		.DEPTH (LETTERS)
	) u_pos_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_v),
		.wdata (fill_w),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	pfe_ram #(
		.WIDTH (LTR_W),
		.DEPTH (SQ_CELLS)
	) u_key_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (fill_w),
		.wdata (pl_v),
		.raddr (ks_raddr),
		.rdata (ks_rdata)
	);

	assign out_letter = ASCII_A_UP[6:0] + 7'(cmd.emit_second ? l2_q : l1_q);
	assign out_end    = cmd.emit_second && end_q;

endmodule

// File: rtl/core/playfair_digraph_encryptor.sv
// top level of the playfair digraph encryptor: controller, datapath and port wiring
//
// channel  direction  fields
// s_axis   in         tdata: char_code, tuser: command, tlast: message_last
// m_axis   out        tdata: cipher_letter, tuser: message_end, tlast: pair_last
//
// keyword, ignored and held message requests are taken without leaving the idle state
// end of keyword walks all 26 letters, one per cycle, then returns to idle
// a digraph goes through position and square ram lookups (RDA, RDB, CALC, RD2, CAP2), then two letters out
// no request is taken until both letters of a digraph have left
// arst_n clears the used flags, fill count, pending letter and key ready flag
module playfair_digraph_encryptor import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_code
	input  logic [1:0] s_axis_tuser,  // [1:0] command
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [6:0] cipher_letter, [7] zero
	output logic       m_axis_tuser,  // [0] message_end
	output logic       m_axis_tlast
);

	ctl_cmd_t   cmd;
	dp_sts_t    sts;
	logic [6:0] letter;

	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfe_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_cmd     (s_axis_tuser),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.out_letter (letter),
		.out_end    (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, letter};
	assign m_axis_tlast = cmd.emit_second;

	a_no_take_while_out : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request taken while a result is pending");

	a_end_on_second : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
		else $error("message end on first letter of a pair");

	a_pair_closes : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("result after second letter of a pair");

	a_first_then_second : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
		else $error("second letter of a pair missing");

endmodule

// File: tb/playfair_digraph_encryptor_tb.sv
// self-checking testbench of the playfair digraph encryptor: directed and random streams checked against a predictor
module playfair_digraph_encryptor_tb;
	import pfe_pkg::*;

	localparam int RANDOM_REQUESTS = 1950;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PHASE_LEN       = 250;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] code;
		logic       last;
	} request_t;

	typedef struct packed {
		logic [6:0] letter;
		logic       msg_end;
		logic       pair_last;
	} cipher_out_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic [1:0] s_axis_tuser  = 2'd0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	playfair_digraph_encryptor uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t    plain_requests[$];
	cipher_out_t expected_cipher[$];
	request_t    active_req;

	// predictor state
	logic [LTR_W-1:0]  key_cells[SQ_CELLS];
	logic [CELL_W-1:0] cell_of_letter[LETTERS];
	bit                letter_placed[LETTERS];
	logic [4:0]        cells_filled = 5'd0;
	logic [LTR_W-1:0]  held_letter = '0;
	bit                letter_pending = 1'b0;
	bit                key_built = 1'b0;

	int errors = 0;
	int requests_taken = 0;
	int letters_checked = 0;
	int keys_built = 0;
	int row_pairs = 0;
	int col_pairs = 0;
	int rect_pairs = 0;
	int cycle_count = 0;

	function automatic int fold_letter(logic [7:0] code);
		logic [7:0] up;
		int         idx;
		up = code;
		if (up >= ASCII_A_LO && up <= ASCII_Z_LO) begin
			up = up - CASE_DIFF;
		end
		if (up < ASCII_A_UP || up > ASCII_Z_UP) begin
			return -1;
		end
		idx = int'(up) - int'(ASCII_A_UP);
		return (idx == int'(IDX_J)) ? int'(IDX_I) : idx;
	endfunction

	task automatic place_letter(int idx);
		if (cells_filled < SQ_CELLS && !letter_placed[idx]) begin
			key_cells[cells_filled] = LTR_W'(idx);
			cell_of_letter[idx]     = CELL_W'(cells_filled);
			letter_placed[idx]      = 1'b1;
			cells_filled++;
		end
	endtask

	task automatic encrypt_digraph(int a, int b, bit closes);
		int ra, ca, rb, cb, oa, ob;
		if (b == a) begin
			b = int'(IDX_X);
		end
		ra = int'(cell_of_letter[a]) / SQ_SIDE;
		ca = int'(cell_of_letter[a]) % SQ_SIDE;
		rb = int'(cell_of_letter[b]) / SQ_SIDE;
		cb = int'(cell_of_letter[b]) % SQ_SIDE;
		if (ra == rb) begin
			oa = ra * SQ_SIDE + (ca + 1) % SQ_SIDE;
			ob = rb * SQ_SIDE + (cb + 1) % SQ_SIDE;
			row_pairs++;
		end else if (ca == cb) begin
			oa = ((ra + 1) % SQ_SIDE) * SQ_SIDE + ca;
			ob = ((rb + 1) % SQ_SIDE) * SQ_SIDE + cb;
			col_pairs++;
		end else begin
			oa = ra * SQ_SIDE + cb;
			ob = rb * SQ_SIDE + ca;
			rect_pairs++;
		end
		expected_cipher.push_back({7'(int'(ASCII_A_UP) + int'(key_cells[oa])), 1'b0, 1'b0});
		expected_cipher.push_back({7'(int'(ASCII_A_UP) + int'(key_cells[ob])), closes, 1'b1});
	endtask

	task automatic apply_request(request_t rq);
		int idx;
		idx = fold_letter(rq.code);
		case (rq.cmd)
			CMD_KEY: begin
				if (key_built) begin
					foreach (letter_placed[i]) letter_placed[i] = 1'b0;
					cells_filled   = 5'd0;
					key_built      = 1'b0;
					letter_pending = 1'b0;
					held_letter    = '0;
				end
				if (idx >= 0) place_letter(idx);
			end
			CMD_END: begin
				if (!key_built) begin
					for (int c = 0; c < LETTERS; c++) begin
						if (c != int'(IDX_J)) place_letter(c);
					end
					key_built = 1'b1;
					keys_built++;
				end
			end
			CMD_MSG: begin
				if (key_built) begin
					if (idx < 0) begin
						if (rq.last && letter_pending) begin
							letter_pending = 1'b0;
							encrypt_digraph(int'(held_letter), int'(IDX_X), 1'b1);
						end
					end else if (letter_pending) begin
						letter_pending = 1'b0;
						encrypt_digraph(int'(held_letter), idx, rq.last);
					end else if (rq.last) begin
						encrypt_digraph(idx, int'(IDX_X), 1'b1);
					end else begin
						held_letter    = LTR_W'(idx);
						letter_pending = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// idling mode rotates every 250 requests
	function automatic int sender_idle_pct();
		case ((requests_taken / PHASE_LEN) % 4)
			1: return 82;
			3: return 37;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case ((requests_taken / PHASE_LEN) % 4)
			2: return 82;
			3: return 37;
			default: return 0;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(active_req);
				requests_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (plain_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					active_req = plain_requests.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= active_req.code;
					s_axis_tuser  <= active_req.cmd;
					s_axis_tlast  <= active_req.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		cipher_out_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_cipher.size() == 0) begin
					$display("%0t: unexpected letter tdata=%02h tuser=%b tlast=%b", $time,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = expected_cipher.pop_front();
					letters_checked++;
					if (m_axis_tdata !== {1'b0, want.letter} || m_axis_tuser !== want.msg_end ||
							m_axis_tlast !== want.pair_last) begin
						$display("%0t: mismatch expected %c end=%b last=%b, actual tdata=%02h end=%b last=%b",
							$time, want.letter, want.msg_end, want.pair_last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d letters still expected", $time, expected_cipher.size());
			$display("playfair_digraph_encryptor regression: fail");
			$finish;
		end
	end

	task automatic add_request(cmd_t cmd, logic [7:0] code, logic last);
		plain_requests.push_back('{cmd, code, last});
	endtask

	function automatic logic [7:0] letter_code(int idx);
		return ($urandom_range(1) ? ASCII_A_LO : ASCII_A_UP) + 8'(idx);
	endfunction

	task automatic add_noise();
		add_request(cmd_t'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic build_random_stimulus();
		int kw_len, n_msgs, msg_len, prev, idx;
		logic [7:0] code;
		while (plain_requests.size() < RANDOM_REQUESTS + 25) begin
			// keyword, now and then long enough to fill the square by itself
			kw_len = ($urandom_range(9) == 0) ? 40 : $urandom_range(14);
			for (int k = 0; k < kw_len; k++) begin
				if ($urandom_range(99) < 85) begin
					add_request(CMD_KEY, letter_code($urandom_range(25)), 1'($urandom_range(1)));
				end else begin
					add_request(CMD_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
				end
				if ($urandom_range(49) == 0) begin
					add_request(CMD_MSG, letter_code($urandom_range(25)), 1'($urandom_range(1)));
				end
			end
			add_request(CMD_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
			if ($urandom_range(9) == 0) begin
				add_request(CMD_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end
			n_msgs = $urandom_range(4, 1);
			for (int m = 0; m < n_msgs; m++) begin
				msg_len = $urandom_range(16, 1);
				prev = $urandom_range(25);
				for (int k = 0; k < msg_len; k++) begin
					if ($urandom_range(99) < 10) begin
						code = 8'($urandom_range(255));
					end else begin
						idx = ($urandom_range(99) < 15) ? prev : $urandom_range(25);
						code = letter_code(idx);
						prev = idx;
					end
					add_request(CMD_MSG, code,
						(k == msg_len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0));
					if ($urandom_range(99) < 2) add_noise();
				end
			end
		end
	endtask

	initial begin
		// message before any key, then an ignored command
		add_request(CMD_MSG, "A", 1'b1);
		add_request(CMD_NONE, 8'hFF, 1'b1);
		// keyword with case folding, J, a non-letter and a repeat
		add_request(CMD_KEY, "m", 1'b0);
		add_request(CMD_KEY, "O", 1'b0);
		add_request(CMD_KEY, "N", 1'b0);
		add_request(CMD_KEY, "j", 1'b0);
		add_request(CMD_KEY, 8'hFF, 1'b1);
		add_request(CMD_KEY, "z", 1'b0);
		add_request(CMD_KEY, "M", 1'b0);
		add_request(CMD_END, 8'h00, 1'b0);
		add_request(CMD_END, 8'hFF, 1'b1);
		add_request(CMD_MSG, "H", 1'b0);
		add_request(CMD_MSG, "i", 1'b0);
		// doubled letters, X doubled
		add_request(CMD_MSG, "L", 1'b0);
		add_request(CMD_MSG, "L", 1'b0);
		add_request(CMD_MSG, "X", 1'b0);
		add_request(CMD_MSG, "x", 1'b0);
		// dropped non-letter, padded lone letters, empty end
		add_request(CMD_MSG, "!", 1'b0);
		add_request(CMD_MSG, "a", 1'b1);
		add_request(CMD_MSG, "q", 1'b0);
		add_request(CMD_MSG, 8'h80, 1'b1);
		add_request(CMD_MSG, 8'h00, 1'b1);
		// pending letter dropped by a new keyword
		add_request(CMD_MSG, "j", 1'b0);
		add_request(CMD_KEY, "b", 1'b0);
		add_request(CMD_END, 8'h00, 1'b0);
		build_random_stimulus();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (plain_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_cipher.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests taken %0d, keys built %0d, cipher letters checked %0d",
			requests_taken, keys_built, letters_checked);
		$display("digraphs by rule: same row %0d, same column %0d, rectangle %0d",
			row_pairs, col_pairs, rect_pairs);
		if (errors == 0 && expected_cipher.size() == 0) begin
			$display("playfair_digraph_encryptor regression: pass");
		end else begin
			$display("playfair_digraph_encryptor regression: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_ctrl.sv
rtl/core/pfe_datapath.sv
rtl/core/playfair_digraph_encryptor.sv
tb/playfair_digraph_encryptor_tb.sv
